// File: rtl/core/pss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pss_pkg;

    localparam int MAX_MOTIF_LEN = 32;
    localparam int NUM_BASES     = 4;
    localparam int W_BITS        = 16;
    localparam int OUT_BITS      = 21;
    localparam int LEN_BITS      = 6;
    localparam int POS_BITS      = $clog2(MAX_MOTIF_LEN);
    localparam int CODE_BITS     = 3;
    localparam int BASE_BITS     = $clog2(NUM_BASES);

    typedef logic [CODE_BITS-1:0]        t_code;
    typedef logic signed [W_BITS-1:0]    t_weight;
    typedef t_weight [NUM_BASES-1:0]     t_wt_col;
    typedef logic signed [OUT_BITS-1:0]  t_score;

    localparam t_code CODE_A  = 3'd0;
    localparam t_code CODE_G  = 3'd1;
    localparam t_code CODE_C  = 3'd2;
    localparam t_code CODE_T  = 3'd3;
    localparam t_code NO_BASE = 3'd4;

    // broadcast to every weight cell
    typedef struct packed {
        logic                  rotate;
        logic [BASE_BITS-1:0]  wr_base;
        t_weight               wr_value;
    } t_wt_ctl;

    function automatic t_code base_code(input logic [7:0] ch);
        t_code code;
        case (ch)
            8'h41, 8'h61: code = CODE_A;
            8'h47, 8'h67: code = CODE_G;
            8'h43, 8'h63: code = CODE_C;
            8'h54, 8'h74: code = CODE_T;
            default:      code = NO_BASE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/pss_hist_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// one position of the base history ring
module pss_hist_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_adv,
    input  pss_pkg::t_code      i_prev,
    output pss_pkg::t_code      o_code
);

    pss_pkg::t_code r_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= pss_pkg::NO_BASE;
        end else if (i_adv) begin
            r_code <= i_prev;
        end
    end

    assign o_code = r_code;

endmodule

`default_nettype wire

// File: rtl/core/pss_wt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// one matrix column (all four bases) in the rotating weight ring
module pss_wt_cell (
    input  wire                 i_clk,
    input  pss_pkg::t_wt_ctl    i_ctl,
    input  wire                 i_wr_en,
    input  pss_pkg::t_wt_col    i_next,
    output pss_pkg::t_wt_col    o_col
);

    pss_pkg::t_wt_col r_col;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rotate) begin
            r_col <= i_next;
        end else if (i_wr_en) begin
            r_col[i_ctl.wr_base] <= i_ctl.wr_value;
        end
    end

    assign o_col = r_col;

endmodule

`default_nettype wire

// File: rtl/core/pwm_sequence_scan.sv
`timescale 1ns / 1ps
`default_nettype none

// Position weight matrix scanner. A load transaction (func 0) writes one Q8.8 weight
// into the column cell it names. A base transaction (func 1) shifts its base into a
// 32-position history ring; when the window is not yet full the block stays idle. When
// the window is full it starts a scan: the weight ring and the history ring each rotate
// through all 32 cells, one step per cycle, while a single 21-bit adder sums one column
// per cycle. The score is complete at the end of the scan and is written to the output
// register from the done state, once that register is free. The input is ready again
// only when the block returns to idle, so no new transaction is taken during a scan or
// while its score waits to be written. A score waiting in the output register does not
// block loads or bases that do not score, but the next scoring base holds the input after
// its scan until that score is taken. The user must write motif_length only while the
// block is idle; the block itself does not enforce this.
module pwm_sequence_scan (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [pss_pkg::LEN_BITS-1:0]    i_cfg_data,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire                             i_func,
    input  wire  [7:0]                      i_base_char,
    input  wire                             i_last_in_sequence,
    input  wire  [pss_pkg::POS_BITS-1:0]    i_weight_column,
    input  wire  [pss_pkg::BASE_BITS-1:0]   i_weight_base,
    input  wire  signed [pss_pkg::W_BITS-1:0] i_weight_value,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic signed [pss_pkg::OUT_BITS-1:0] o_window_score
);

    localparam int N = pss_pkg::MAX_MOTIF_LEN;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state                         r_state;
    logic [pss_pkg::LEN_BITS-1:0]   r_motif;
    logic [pss_pkg::LEN_BITS-1:0]   r_fill;
    logic [pss_pkg::POS_BITS-1:0]   r_k;
    pss_pkg::t_score                r_acc;
    logic                           r_out_valid;
    pss_pkg::t_score                r_out_score;

    logic                           accept;
    logic                           base_acc;
    logic                           scan;
    logic [pss_pkg::LEN_BITS-1:0]   len;
    logic [pss_pkg::POS_BITS-1:0]   len_m1;
    logic [pss_pkg::LEN_BITS-1:0]   n_fill;
    pss_pkg::t_code                 tap_code;
    pss_pkg::t_weight               tap_w;
    pss_pkg::t_score                term;
    pss_pkg::t_wt_ctl               wt_ctl;

    pss_pkg::t_code                 h_code [N];
    pss_pkg::t_code                 h_prev [N];
    pss_pkg::t_wt_col               w_col  [N];

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign base_acc   = accept && i_func;
    assign scan       = (r_state == S_SCAN);

    // zero acts as one, oversize acts as the full ring
    always_comb begin
        if (r_motif == '0) begin
            len = pss_pkg::LEN_BITS'(1);
        end else if (r_motif > pss_pkg::LEN_BITS'(N)) begin
            len = pss_pkg::LEN_BITS'(N);
        end else begin
            len = r_motif;
        end
    end
    assign len_m1 = pss_pkg::POS_BITS'(len - pss_pkg::LEN_BITS'(1));

    assign n_fill = (r_fill < pss_pkg::LEN_BITS'(N)) ? r_fill + pss_pkg::LEN_BITS'(1) : r_fill;

    // history ring: new base enters cell 0 on a base transaction, cell 0 wraps during scan
    assign h_prev[0] = scan ? h_code[N-1] : pss_pkg::base_code(i_base_char);
    for (genvar i = 1; i < N; i++) begin : g_hprev
        assign h_prev[i] = h_code[i-1];
    end

    for (genvar i = 0; i < N; i++) begin : g_hist
        pss_hist_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (base_acc || scan),
            .i_prev  (h_prev[i]),
            .o_code  (h_code[i])
        );
    end

    assign wt_ctl.rotate   = scan;
    assign wt_ctl.wr_base  = i_weight_base;
    assign wt_ctl.wr_value = i_weight_value;

    // weight ring rotates toward cell 0, so cell 0 holds column k at scan step k
    for (genvar c = 0; c < N; c++) begin : g_wt
        localparam int NXT = (c + 1) % N;
        pss_wt_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (wt_ctl),
            .i_wr_en (accept && !i_func && (i_weight_column == pss_pkg::POS_BITS'(c))),
            .i_next  (w_col[NXT]),
            .o_col   (w_col[c])
        );
    end

    // at step k the history tap at len-1 holds the base for column k
    assign tap_code = h_code[len_m1];
    assign tap_w    = w_col[0][tap_code[pss_pkg::BASE_BITS-1:0]];

    always_comb begin
        if ((tap_code != pss_pkg::NO_BASE) && ({1'b0, r_k} < len)) begin
            term = {{(pss_pkg::OUT_BITS-pss_pkg::W_BITS){tap_w[pss_pkg::W_BITS-1]}}, tap_w};
        end else begin
            term = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_motif     <= pss_pkg::LEN_BITS'(1);
            r_fill      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_motif <= i_cfg_data;
            end
            // in the done state the output register is reloaded whenever it is taken
            if (o_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (base_acc) begin
                        r_fill <= i_last_in_sequence ? '0 : n_fill;
                        if (n_fill >= len) begin
                            r_state <= S_SCAN;
                            r_k     <= '0;
                            r_acc   <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    r_acc <= r_acc + term;
                    r_k   <= r_k + pss_pkg::POS_BITS'(1);
                    if (r_k == pss_pkg::POS_BITS'(N - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_score <= r_acc;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_window_score = r_out_score;

endmodule

`default_nettype wire
